>>> hdl/tksk_pkg.sv
// ----------------------------------------------------------------------------
// tksk_pkg
// Shared constants, result codes and helpers for the top-k score keeper.
// ----------------------------------------------------------------------------
package tksk_pkg;

   // Built capacity of the kept list
   localparam int MAX_KEEP = 16;

   // Field widths
   localparam int CNT_W   = $clog2(MAX_KEEP + 1);
   localparam int IDX_W   = $clog2(MAX_KEEP);
   localparam int SCORE_W = 32;
   localparam int TAG_W   = 16;
   localparam int KIND_W  = 2;

   // Reset value of the keep count register
   localparam logic [CNT_W-1:0] KEEP_RESET = CNT_W'(MAX_KEEP);

   // Request actions
   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_READ   = 1'b1;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ENTRY  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;

   // Clamp a keep count to the range 1..MAX_KEEP
   function automatic logic [CNT_W-1:0] cap_of(input logic [CNT_W-1:0] keep);
      logic [CNT_W-1:0] cap;
      cap = keep;
      if (keep == '0) begin
         cap = CNT_W'(1);
      end else if (keep > CNT_W'(MAX_KEEP)) begin
         cap = CNT_W'(MAX_KEEP);
      end
      return cap;
   endfunction

endpackage

>>> hdl/top_k_score_keeper.sv
// ----------------------------------------------------------------------------
// top_k_score_keeper
// Keeps the best entries seen so far, sorted from highest to lowest score,
// and streams them out in rank order on request.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   req     | in        | req_valid/req_ready  | action, score, tag
//   rsp     | out       | rsp_valid/rsp_ready  | kind, accepted, entry_score,
//           |           |                      | entry_tag, rank, last
//   csr     | in        | csr_write_enable     | keep_count (no read-back)
//
// An insert takes its request beat, then walks the list from its bottom
// up, one compare and one entry move per cycle through a single shared
// comparator, from the first free place with room left; on a full list it
// first tests the lowest entry, drops the item if it scores lower and else
// walks from that place, then hands over the answer beat. A read-out takes
// its request beat, then sends one beat per cycle while no result beat is
// stalled, fill beats (one for an empty list). The request side is ready
// only between items. Reset clears the fill count and sets keep_count to
// its maximum; list entries are not cleared. A stalled result beat holds
// the sequencer at its next beat; a placement walk runs on meanwhile.
// ----------------------------------------------------------------------------
module top_k_score_keeper (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_action,
   input  logic signed [tksk_pkg::SCORE_W-1:0] req_score,
   input  logic        [tksk_pkg::TAG_W-1:0]   req_tag,

   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic        [tksk_pkg::KIND_W-1:0]  rsp_kind,
   output logic                               rsp_accepted,
   output logic signed [tksk_pkg::SCORE_W-1:0] rsp_entry_score,
   output logic        [tksk_pkg::TAG_W-1:0]   rsp_entry_tag,
   output logic        [tksk_pkg::IDX_W-1:0]   rsp_rank,
   output logic                               rsp_last,

   input  logic                               csr_write_enable,
   input  logic        [tksk_pkg::CNT_W-1:0]   csr_write_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SHIFT,
      ST_ANSWER,
      ST_READ
   } state_type;

   state_type state_ff;

   // Configuration and list control
   logic [tksk_pkg::CNT_W-1:0] keep_ff;
   logic [tksk_pkg::CNT_W-1:0] fill_ff;
   logic [tksk_pkg::IDX_W-1:0] idx_ff;

   // Latched request
   logic signed [tksk_pkg::SCORE_W-1:0] score_ff;
   logic        [tksk_pkg::TAG_W-1:0]   tag_ff;
   logic                               accepted_ff;

   // Result register
   logic                               rsp_valid_ff;
   logic        [tksk_pkg::KIND_W-1:0]  rsp_kind_ff;
   logic                               rsp_accepted_ff;
   logic signed [tksk_pkg::SCORE_W-1:0] rsp_score_ff;
   logic        [tksk_pkg::TAG_W-1:0]   rsp_tag_ff;
   logic        [tksk_pkg::IDX_W-1:0]   rsp_rank_ff;
   logic                               rsp_last_ff;

   // Kept list storage
   logic signed [tksk_pkg::SCORE_W-1:0] kept_score_ff [tksk_pkg::MAX_KEEP];
   logic        [tksk_pkg::TAG_W-1:0]   kept_tag_ff   [tksk_pkg::MAX_KEEP];

   logic        [tksk_pkg::IDX_W-1:0]   rd_addr;
   logic signed [tksk_pkg::SCORE_W-1:0] rd_score;
   logic        [tksk_pkg::TAG_W-1:0]   rd_tag;
   logic signed [tksk_pkg::SCORE_W-1:0] cmp_a;
   logic signed [tksk_pkg::SCORE_W-1:0] cmp_b;
   logic                               cmp_lt;
   logic                               out_free;
   logic                               rsp_load;
   logic                               req_beat;
   logic [tksk_pkg::CNT_W-1:0]         cap;
   logic [tksk_pkg::CNT_W-1:0]         new_cap;
   logic [tksk_pkg::CNT_W-1:0]         idx_next;
   logic                               read_last;
   logic                               move_up;

   assign cap      = tksk_pkg::cap_of(keep_ff);
   assign new_cap  = tksk_pkg::cap_of(csr_write_data);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_load = out_free && ((state_ff == ST_ANSWER) || (state_ff == ST_READ));
   assign req_ready = (state_ff == ST_IDLE);
   assign req_beat  = req_valid && req_ready;

   // Pick the one entry looked at this cycle
   always_comb begin
      unique case (state_ff)
         ST_CHECK: rd_addr = tksk_pkg::IDX_W'(fill_ff - tksk_pkg::CNT_W'(1));
         ST_SHIFT: rd_addr = idx_ff - tksk_pkg::IDX_W'(1);
         default:  rd_addr = idx_ff;
      endcase
   end

   assign rd_score = kept_score_ff[rd_addr];
   assign rd_tag   = kept_tag_ff[rd_addr];

   // Shared signed comparator: reject test on CHECK, move test on SHIFT
   always_comb begin
      if (state_ff == ST_CHECK) begin
         cmp_a = score_ff;
         cmp_b = rd_score;
      end else begin
         cmp_a = rd_score;
         cmp_b = score_ff;
      end
   end

   assign cmp_lt    = cmp_a < cmp_b;
   assign move_up   = (idx_ff != '0) && cmp_lt;
   assign idx_next  = {1'b0, idx_ff} + tksk_pkg::CNT_W'(1);
   assign read_last = (idx_next == fill_ff);

   // Write the list: move an entry down one place or drop the new item in
   always_ff @(posedge clock) begin
      if (state_ff == ST_SHIFT) begin
         if (move_up) begin
            kept_score_ff[idx_ff] <= rd_score;
            kept_tag_ff[idx_ff]   <= rd_tag;
         end else begin
            kept_score_ff[idx_ff] <= score_ff;
            kept_tag_ff[idx_ff]   <= tag_ff;
         end
      end
   end

   // Sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         keep_ff      <= tksk_pkg::KEEP_RESET;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Load a new beat or drop the one just taken
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         // Truncate the list to the new capacity
         if (csr_write_enable) begin
            keep_ff <= csr_write_data;
            if (fill_ff > new_cap) begin
               fill_ff <= new_cap;
            end
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_beat) begin
                  score_ff  <= req_score;
                  tag_ff    <= req_tag;
                  if (req_action == tksk_pkg::ACT_READ) begin
                     idx_ff   <= '0;
                     state_ff <= ST_READ;
                  end else if (fill_ff < cap) begin
                     idx_ff      <= tksk_pkg::IDX_W'(fill_ff);
                     fill_ff     <= fill_ff + tksk_pkg::CNT_W'(1);
                     accepted_ff <= 1'b1;
                     state_ff    <= ST_SHIFT;
                  end else begin
                     state_ff <= ST_CHECK;
                  end
               end
            end

            ST_CHECK: begin
               if (cmp_lt) begin
                  accepted_ff <= 1'b0;
                  state_ff    <= ST_ANSWER;
               end else begin
                  accepted_ff <= 1'b1;
                  idx_ff      <= rd_addr;
                  state_ff    <= ST_SHIFT;
               end
            end

            ST_SHIFT: begin
               if (move_up) begin
                  idx_ff <= rd_addr;
               end else begin
                  state_ff <= ST_ANSWER;
               end
            end

            ST_ANSWER: begin
               if (out_free) begin
                  rsp_kind_ff     <= tksk_pkg::KIND_INSERT;
                  rsp_accepted_ff <= accepted_ff;
                  rsp_score_ff    <= '0;
                  rsp_tag_ff      <= '0;
                  rsp_rank_ff     <= '0;
                  rsp_last_ff     <= 1'b1;
                  state_ff        <= ST_IDLE;
               end
            end

            ST_READ: begin
               if (out_free) begin
                  rsp_accepted_ff <= 1'b0;
                  if (fill_ff == '0) begin
                     rsp_kind_ff  <= tksk_pkg::KIND_EMPTY;
                     rsp_score_ff <= '0;
                     rsp_tag_ff   <= '0;
                     rsp_rank_ff  <= '0;
                     rsp_last_ff  <= 1'b1;
                     state_ff     <= ST_IDLE;
                  end else begin
                     rsp_kind_ff  <= tksk_pkg::KIND_ENTRY;
                     rsp_score_ff <= rd_score;
                     rsp_tag_ff   <= rd_tag;
                     rsp_rank_ff  <= idx_ff;
                     rsp_last_ff  <= read_last;
                     idx_ff       <= idx_ff + tksk_pkg::IDX_W'(1);
                     if (read_last) begin
                        state_ff <= ST_IDLE;
                     end
                  end
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_accepted    = rsp_accepted_ff;
   assign rsp_entry_score = rsp_score_ff;
   assign rsp_entry_tag   = rsp_tag_ff;
   assign rsp_rank        = rsp_rank_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef SYNTHESIS
   // The fill count never passes the built capacity
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= tksk_pkg::CNT_W'(tksk_pkg::MAX_KEEP))
      else $error("fill count above built capacity");

   // An accepted request closes the request side on the next cycle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request side still open after a request beat");

   // A placement walk ends only by handing over an insert answer
   a_shift_exit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SHIFT |=> state_ff == ST_SHIFT || state_ff == ST_ANSWER)
      else $error("placement walk left to a wrong state");

   // Non-entry beats carry zero entry fields
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != tksk_pkg::KIND_ENTRY |->
         rsp_entry_score == '0 && rsp_entry_tag == '0 && rsp_rank == '0 && rsp_last)
      else $error("non-entry beat with entry fields set");
`endif

endmodule
